@@ rtl/lce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lce_pkg;

	// payload widths
	localparam int OP_W        = 2;
	localparam int ROW_W       = 7;
	localparam int COL_W       = 8;
	localparam int ROWS_USED_W = 8;
	localparam int COLS_USED_W = 9;
	localparam int CFG_ADDR_W  = 1;
	localparam int CFG_DATA_W  = 9;

	// default grid bounds
	localparam int MAX_ROWS_DEF = 128;
	localparam int MAX_COLS_DEF = 256;

	// register reset values
	localparam logic [ROWS_USED_W-1:0] ROWS_USED_RST = 8'd90;
	localparam logic [COLS_USED_W-1:0] COLS_USED_RST = 9'd160;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_ROWS_USED = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_COLS_USED = 1'b1;

	// operation codes
	localparam logic [OP_W-1:0] OP_SET  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ = 2'd1;
	localparam logic [OP_W-1:0] OP_STEP = 2'd2;

	// B3/S23 neighbor counts
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	// line buffer control
	typedef struct packed {
		logic re;     // read both banks at rd_col
		logic we;     // write one bank at wr_col
		logic wbank;  // bank selected for write
		logic wd;     // write data
	} lb_ctl_t;

endpackage

`default_nettype wire

@@ rtl/lce_item_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lce_item_if;
	import lce_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] col;

	modport source (output valid, output operation, output row, output col, input ready);
	modport sink   (input valid, input operation, input row, input col, output ready);
endinterface

`default_nettype wire

@@ rtl/lce_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lce_result_if;
	logic valid;
	logic ready;
	logic cell_alive;
	logic out_of_range;

	modport source (output valid, output cell_alive, output out_of_range, input ready);
	modport sink   (input valid, input cell_alive, input out_of_range, output ready);
endinterface

`default_nettype wire

@@ rtl/lce_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lce_cfg_if;
	import lce_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/lce_line_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-row store of old cell values, one bank per row parity.
module lce_line_buf #(
	parameter int MAX_COLS = lce_pkg::MAX_COLS_DEF
) (
	input  wire                          clk,
	input  lce_pkg::lb_ctl_t             ctl,
	input  wire  [$clog2(MAX_COLS)-1:0]  rd_col,
	input  wire  [$clog2(MAX_COLS)-1:0]  wr_col,
	output logic                         bank0_q,
	output logic                         bank1_q
);
	import lce_pkg::*;

	logic bank0 [MAX_COLS];
	logic bank1 [MAX_COLS];

	always_ff @(posedge clk) begin
		if (ctl.we && !ctl.wbank) begin
			bank0[wr_col] <= ctl.wd;
		end
		if (ctl.re) begin
			bank0_q <= bank0[rd_col];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.we && ctl.wbank) begin
			bank1[wr_col] <= ctl.wd;
		end
		if (ctl.re) begin
			bank1_q <= bank1[rd_col];
		end
	end

endmodule

`default_nettype wire

@@ rtl/lce_rule.sv @@
`timescale 1ns / 1ps
`default_nettype none

// B3/S23 update of one cell from a 3x3 window.
// Each column is {up, mid, down}; the cell itself is col_c[1].
module lce_rule (
	input  wire  [2:0] col_w,
	input  wire  [2:0] col_c,
	input  wire  [2:0] col_e,
	output logic       alive_next
);
	import lce_pkg::*;

	logic [3:0] count;

	always_comb begin
		count = 4'(col_w[0]) + 4'(col_w[1]) + 4'(col_w[2])
		      + 4'(col_c[0]) + 4'(col_c[2])
		      + 4'(col_e[0]) + 4'(col_e[1]) + 4'(col_e[2]);
		alive_next = (count == BIRTH_COUNT) || (col_c[1] && (count == SURVIVE_COUNT));
	end

endmodule

`default_nettype wire

@@ rtl/life_cellular_automaton_engine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat payload                 Notes
// item      in   operation, row, col          set / read / step request
// result    out  cell_alive, out_of_range     one beat per item beat
// cfg       in   addr, data                   0 rows_used, 1 cols_used; always ready
//
// Flow: set and out-of-range items go from idle through ST_FIN to the result register; a read passes ST_READ first.
// A step sweeps the R x C cells in use with one grid memory
// read and one write per cycle, plus one bubble column per row and a row-0 preload.
// Reset: a clearing pass writes all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) grid entries dead
// (32768 at the defaults); item.ready stays low until it ends.
// Stalls: result is held in an output register; the next item is taken meanwhile and
// its result waits behind it.
module life_cellular_automaton_engine_top #(
	parameter int MAX_ROWS = lce_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = lce_pkg::MAX_COLS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	lce_item_if.sink     item,
	lce_result_if.source result,
	lce_cfg_if.sink      cfg
);
	import lce_pkg::*;

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_PRE   = 3'd3;  // copy old row 0 into bank 0
	localparam logic [2:0] ST_ROWS  = 3'd4;  // sweep rows
	localparam logic [2:0] ST_DRAIN = 3'd5;  // last column lands
	localparam logic [2:0] ST_FIN   = 3'd6;  // hand result to output register

	// ------------------------------------------------------------------
	// Configuration registers; size in effect is clamped to the grid.
	// ------------------------------------------------------------------
	logic [ROWS_USED_W-1:0] rows_used_q;
	logic [COLS_USED_W-1:0] cols_used_q;
	logic [RW:0]            nr;
	logic [CW:0]            nc;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_used_q <= ROWS_USED_RST;
			cols_used_q <= COLS_USED_RST;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_ROWS_USED: rows_used_q <= cfg.data[ROWS_USED_W-1:0];
				REG_COLS_USED: cols_used_q <= cfg.data[COLS_USED_W-1:0];
				default: ;
			endcase
		end
	end

	assign nr = (32'(rows_used_q) >= 32'(MAX_ROWS)) ? (RW+1)'(MAX_ROWS) : (RW+1)'(rows_used_q);
	assign nc = (32'(cols_used_q) >= 32'(MAX_COLS)) ? (CW+1)'(MAX_COLS) : (CW+1)'(cols_used_q);

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [RW-1:0] r_q;      // row being swept
	logic [CW:0]   c_q;      // column issued, nc is the bubble
	logic          res_alive_q, res_oor_q;
	logic          out_valid_q, out_alive_q, out_oor_q;

	logic          acc, oor;
	logic [AW-1:0] acc_addr;
	logic          iss, iss_bub, dn_ok;
	logic [RW:0]   r_nxt;

	assign item.ready = (state_q == ST_IDLE);
	assign acc        = item.valid && item.ready;
	assign oor        = (32'(item.row) >= 32'(nr)) || (32'(item.col) >= 32'(nc));
	assign acc_addr   = {RW'(item.row), CW'(item.col)};

	assign iss     = (state_q == ST_PRE) || (state_q == ST_ROWS);
	assign iss_bub = (c_q == nc);
	assign r_nxt   = {1'b0, r_q} + (RW+1)'(1);
	assign dn_ok   = (r_nxt < nr);

	// ------------------------------------------------------------------
	// Sweep stage 1: memory data for column k_s1 has arrived.
	// ------------------------------------------------------------------
	logic          v_s1, pre_s1, bub_s1, par_s1, up_en_s1, dn_en_s1;
	logic [CW:0]   k_s1;
	logic [RW-1:0] r_s1;
	logic [CW:0]   wcol;
	logic [2:0]    prev1_q, prev2_q, cur;
	logic          up_b, mid_b, dn_b, new_cell;

	logic          grid_rd_q;
	logic          bank0_q, bank1_q;

	// row r sits in bank r[0]; the row above in the other bank
	assign up_b  = up_en_s1 && !bub_s1 && (par_s1 ? bank0_q : bank1_q);
	assign mid_b = !bub_s1 && (par_s1 ? bank1_q : bank0_q);
	assign dn_b  = dn_en_s1 && !bub_s1 && grid_rd_q;
	assign cur   = {up_b, mid_b, dn_b};
	assign wcol  = k_s1 - (CW+1)'(1);

	lce_rule u_rule (
		.col_w      (prev2_q),
		.col_c      (prev1_q),
		.col_e      (cur),
		.alive_next (new_cell)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= iss;
		end
	end

	always_ff @(posedge clk) begin
		pre_s1   <= (state_q == ST_PRE);
		bub_s1   <= iss_bub;
		k_s1     <= c_q;
		r_s1     <= r_q;
		par_s1   <= r_q[0];
		up_en_s1 <= (r_q != '0);
		dn_en_s1 <= dn_ok;
		if (v_s1 && !pre_s1) begin
			if (k_s1 == '0) begin
				prev2_q <= '0;   // west of column 0 is dead
			end else begin
				prev2_q <= prev1_q;
			end
			prev1_q <= cur;
		end
	end

	// ------------------------------------------------------------------
	// Grid memory: one write, one registered read per cycle.
	// ------------------------------------------------------------------
	logic          gw_en, gw_data, gr_en;
	logic [AW-1:0] gw_addr, gr_addr;
	logic          grid [DEPTH];

	always_comb begin
		gw_en   = 1'b0;
		gw_addr = clr_q;
		gw_data = 1'b0;
		if (state_q == ST_CLEAR) begin
			gw_en = 1'b1;
		end else if (acc && (item.operation == OP_SET) && !oor) begin
			gw_en   = 1'b1;
			gw_addr = acc_addr;
			gw_data = 1'b1;
		end else if (v_s1 && !pre_s1 && (k_s1 != '0)) begin
			// new value of cell west of the arriving column
			gw_en   = 1'b1;
			gw_addr = {r_s1, wcol[CW-1:0]};
			gw_data = new_cell;
		end
	end

	always_comb begin
		gr_en   = 1'b0;
		gr_addr = acc_addr;
		if (acc && (item.operation == OP_READ) && !oor) begin
			gr_en = 1'b1;
		end else if ((state_q == ST_PRE) && !iss_bub) begin
			gr_en   = 1'b1;
			gr_addr = {{RW{1'b0}}, c_q[CW-1:0]};
		end else if ((state_q == ST_ROWS) && !iss_bub && dn_ok) begin
			gr_en   = 1'b1;
			gr_addr = {r_nxt[RW-1:0], c_q[CW-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (gw_en) begin
			grid[gw_addr] <= gw_data;
		end
		if (gr_en) begin
			grid_rd_q <= grid[gr_addr];
		end
	end

	// ------------------------------------------------------------------
	// Old-row store. Row below is saved as it is read, into the bank
	// of the row above, which is no longer needed past this column.
	// ------------------------------------------------------------------
	lb_ctl_t       lb_ctl;
	logic [CW-1:0] lb_rd_col, lb_wr_col;

	always_comb begin
		lb_ctl.re    = (state_q == ST_ROWS) && !iss_bub;
		lb_ctl.we    = v_s1 && !bub_s1 && (pre_s1 || dn_en_s1);
		lb_ctl.wbank = pre_s1 ? 1'b0 : !par_s1;
		lb_ctl.wd    = grid_rd_q;
		lb_rd_col    = c_q[CW-1:0];
		lb_wr_col    = k_s1[CW-1:0];
	end

	lce_line_buf #(
		.MAX_COLS (MAX_COLS)
	) u_line_buf (
		.clk     (clk),
		.ctl     (lb_ctl),
		.rd_col  (lb_rd_col),
		.wr_col  (lb_wr_col),
		.bank0_q (bank0_q),
		.bank1_q (bank1_q)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			res_alive_q <= 1'b0;
			res_oor_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						case (item.operation)
							OP_SET, OP_READ: begin
								res_oor_q   <= oor;
								res_alive_q <= !oor && (item.operation == OP_SET);
								if (!oor && (item.operation == OP_READ)) begin
									state_q <= ST_READ;
								end else begin
									state_q <= ST_FIN;
								end
							end
							OP_STEP: begin
								res_alive_q <= 1'b0;
								res_oor_q   <= 1'b0;
								if ((nr != '0) && (nc != '0)) begin
									r_q     <= '0;
									c_q     <= '0;
									state_q <= ST_PRE;
								end else begin
									state_q <= ST_FIN;
								end
							end
							default: begin
								res_alive_q <= 1'b0;
								res_oor_q   <= 1'b0;
								state_q     <= ST_FIN;
							end
						endcase
					end
				end
				ST_READ: begin
					res_alive_q <= grid_rd_q;
					state_q     <= ST_FIN;
				end
				ST_PRE: begin
					if (iss_bub) begin
						c_q     <= '0;
						state_q <= ST_ROWS;
					end else begin
						c_q <= c_q + (CW+1)'(1);
					end
				end
				ST_ROWS: begin
					if (iss_bub) begin
						c_q <= '0;
						if (r_nxt == nr) begin
							state_q <= ST_DRAIN;
						end else begin
							r_q <= r_nxt[RW-1:0];
						end
					end else begin
						c_q <= c_q + (CW+1)'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && (!out_valid_q || result.ready)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && (!out_valid_q || result.ready)) begin
			out_alive_q <= res_alive_q;
			out_oor_q   <= res_oor_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.cell_alive   = out_alive_q;
	assign result.out_of_range = out_oor_q;

endmodule

`default_nettype wire
